FILE: sv/swfr_pkg.sv
// ----------------------------------------------------------------------------
// swfr_pkg
// Types, codes and helpers shared by the stop-and-wait frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  // Defaults for the top-level parameters
  localparam int PAYLOAD_BYTES_DEF = 509;
  localparam int LENGTH_BITS_DEF   = 24;

  // Address field width in commands; covers frames up to 1024 bytes
  localparam int ADDR_BITS   = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam int COUNT_BITS  = 9;
  localparam int MSGLEN_BITS = 24;

  localparam logic [7:0] CODE_ACK  = 8'h01;
  localparam logic [7:0] CODE_NAK  = 8'h02;
  localparam logic [7:0] FLAG_LAST = 8'h08;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;
  localparam logic [7:0] SEQ_INIT  = 8'hFF;

  localparam logic OP_FRAME_BYTE = 1'b0;
  localparam logic OP_READ       = 1'b1;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_READ    = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       frame_end;
    logic [8:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic                   result_kind;
    logic [7:0]             reply_sum;
    logic [7:0]             reply_code;
    logic [7:0]             reply_seq;
    logic                   new_data;
    logic                   end_of_message;
    logic [COUNT_BITS-1:0]  payload_count;
    logic [MSGLEN_BITS-1:0] message_length;
    logic [7:0]             read_data;
  } out_item_t;

  // Command from the front end to the back end
  typedef struct packed {
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [7:0]           wr_data;
    logic                 emit;
    logic                 rd_en;
    logic [ADDR_BITS-1:0] rd_addr;
    out_item_t            item;
  } cmd_t;

  // 8-bit add with end-around carry
  function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[7:0] + {7'd0, t[8]};
  endfunction

endpackage

FILE: sv/swfr_queue.sv
// ----------------------------------------------------------------------------
// swfr_queue
// Small register FIFO with occupancy count.
// ----------------------------------------------------------------------------
module swfr_queue #(
  parameter type item_t = logic,
  parameter int  DEPTH  = swfr_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  item_t                      push_item,
  output logic                       full,
  input  logic                       pop,
  output item_t                      pop_item,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  item_t               slot_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign full     = (count_r == CNT_BITS'(DEPTH));
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_item = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: sv/swfr_front.sv
// ----------------------------------------------------------------------------
// swfr_front
// Accepts frame bytes and read requests, keeps the checksum and sequence
// state, decides the verdict and issues ordered commands to the back end.
// ----------------------------------------------------------------------------
module swfr_front #(
  parameter int PAYLOAD_BYTES = swfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int LENGTH_BITS   = swfr_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  swfr_pkg::in_item_t in_data,
  output logic               in_full,
  input  logic               cmd_full,
  output logic               cmd_push,
  output swfr_pkg::cmd_t     cmd
);

  localparam int FRAME_BYTES = PAYLOAD_BYTES + 4;
  localparam int PW = $clog2(FRAME_BYTES + 1);
  localparam int RW = ((PW > 9) ? PW : 9) + 1;
  localparam int CW = $clog2(PAYLOAD_BYTES + 1);
  localparam int NW = (CW > 8) ? CW : 8;
  localparam int LW = LENGTH_BITS;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] pad_r, pad_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic          over_r, over_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    last_seq_r, last_seq_nxt;
  logic [LW-1:0] total_r, total_nxt;
  logic          is_last_r, is_last_nxt;

  logic          accept;
  logic          in_range;
  logic [PW-1:0] pos_after;
  logic [7:0]    sum_after;
  logic          over_after;
  logic [7:0]    flag_cur, seq_cur, len_cur;
  logic [7:0]    flag_eff, seq_eff, len_eff;
  logic          good, new_frame, last_frame;
  logic [7:0]    code;
  logic [NW-1:0] count;
  logic [LW-1:0] base;
  logic [LW:0]   total_sum;
  logic [LW-1:0] total_sat;
  logic [PW-1:0] region;
  logic [RW-1:0] rd_addr;
  logic          rd_ok;

  assign accept  = in_push && !cmd_full;
  assign in_full = cmd_full;

  // Byte path
  assign in_range   = (pos_r < PW'(FRAME_BYTES));
  assign pos_after  = in_range ? pos_r + 1'b1 : pos_r;
  assign sum_after  = in_range ? swfr_pkg::fold_add(sum_r, in_data.data_byte) : sum_r;
  assign over_after = over_r | !in_range;
  assign flag_cur   = (in_range && pos_r == PW'(1)) ? in_data.data_byte : flag_r;
  assign seq_cur    = (in_range && pos_r == PW'(2)) ? in_data.data_byte : seq_r;
  assign len_cur    = (in_range && pos_r == PW'(3)) ? in_data.data_byte : len_r;

  // Header bytes beyond a short frame read as zero padding
  assign flag_eff = (pos_after > PW'(1)) ? flag_cur : 8'd0;
  assign seq_eff  = (pos_after > PW'(2)) ? seq_cur : 8'd0;
  assign len_eff  = (pos_after > PW'(3)) ? len_cur : 8'd0;

  // Verdict
  assign good       = (sum_after == swfr_pkg::SUM_GOOD);
  assign code       = good ? swfr_pkg::CODE_ACK : swfr_pkg::CODE_NAK;
  assign new_frame  = good && (seq_eff != last_seq_r);
  assign last_frame = (flag_eff == swfr_pkg::FLAG_LAST);

  always_comb begin
    if (!last_frame) begin
      count = NW'(PAYLOAD_BYTES);
    end else if (NW'(len_eff) > NW'(PAYLOAD_BYTES)) begin
      count = NW'(PAYLOAD_BYTES);
    end else begin
      count = NW'(len_eff);
    end
  end

  // Restart the total on the first delivery after a LAST frame
  assign base      = is_last_r ? '0 : total_r;
  assign total_sum = {1'b0, base} + (LW + 1)'(count);
  assign total_sat = total_sum[LW] ? {LW{1'b1}} : total_sum[LW-1:0];

  // Read path: written region covers the current frame and the last padded one
  assign region  = (pos_r > pad_r) ? pos_r : pad_r;
  assign rd_addr = ((flag_r == swfr_pkg::FLAG_LAST) ? RW'(4) : RW'(3))
                   + RW'(in_data.read_index);
  assign rd_ok   = (RW'(in_data.read_index) < RW'(PAYLOAD_BYTES))
                   && (rd_addr < RW'(region));

  always_comb begin
    pos_nxt      = pos_r;
    pad_nxt      = pad_r;
    sum_nxt      = sum_r;
    over_nxt     = over_r;
    flag_nxt     = flag_r;
    seq_nxt      = seq_r;
    len_nxt      = len_r;
    last_seq_nxt = last_seq_r;
    total_nxt    = total_r;
    is_last_nxt  = is_last_r;
    cmd          = '0;
    cmd_push     = 1'b0;

    if (accept) begin
      if (in_data.operation == swfr_pkg::OP_READ) begin
        cmd.emit             = 1'b1;
        cmd.rd_en            = rd_ok;
        cmd.rd_addr          = swfr_pkg::ADDR_BITS'(rd_addr);
        cmd.item.result_kind = swfr_pkg::KIND_READ;
        cmd_push             = 1'b1;
      end else begin
        cmd.wr_en   = in_range;
        cmd.wr_addr = swfr_pkg::ADDR_BITS'(pos_r);
        cmd.wr_data = in_data.data_byte;
        flag_nxt    = flag_cur;
        seq_nxt     = seq_cur;
        len_nxt     = len_cur;
        if (!in_data.frame_end) begin
          pos_nxt  = pos_after;
          sum_nxt  = sum_after;
          over_nxt = over_after;
        end else begin
          pos_nxt  = '0;
          sum_nxt  = '0;
          over_nxt = 1'b0;
          pad_nxt  = pos_after;
          if (!over_after) begin
            // Drop nothing: answer with a verdict
            flag_nxt                = flag_eff;
            seq_nxt                 = seq_eff;
            len_nxt                 = len_eff;
            cmd.emit                = 1'b1;
            cmd.item.result_kind    = swfr_pkg::KIND_VERDICT;
            cmd.item.reply_code     = code;
            cmd.item.reply_seq      = seq_eff;
            cmd.item.reply_sum      = ~swfr_pkg::fold_add(code, seq_eff);
            cmd.item.new_data       = new_frame;
            cmd.item.message_length = swfr_pkg::MSGLEN_BITS'(total_r);
            if (new_frame) begin
              last_seq_nxt            = seq_eff;
              is_last_nxt             = last_frame;
              total_nxt               = total_sat;
              cmd.item.end_of_message = last_frame;
              cmd.item.payload_count  = swfr_pkg::COUNT_BITS'(count);
              cmd.item.message_length = swfr_pkg::MSGLEN_BITS'(total_sat);
            end
          end
        end
        cmd_push = cmd.wr_en || cmd.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pad_r      <= '0;
      sum_r      <= '0;
      over_r     <= 1'b0;
      flag_r     <= '0;
      seq_r      <= '0;
      len_r      <= '0;
      last_seq_r <= swfr_pkg::SEQ_INIT;
      total_r    <= '0;
      is_last_r  <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      pad_r      <= pad_nxt;
      sum_r      <= sum_nxt;
      over_r     <= over_nxt;
      flag_r     <= flag_nxt;
      seq_r      <= seq_nxt;
      len_r      <= len_nxt;
      last_seq_r <= last_seq_nxt;
      total_r    <= total_nxt;
      is_last_r  <= is_last_nxt;
    end
  end

endmodule

FILE: sv/swfr_back.sv
// ----------------------------------------------------------------------------
// swfr_back
// Executes commands in order: writes the frame store, reads payload bytes
// and queues results for the output side.
// ----------------------------------------------------------------------------
module swfr_back #(
  parameter int PAYLOAD_BYTES = swfr_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  swfr_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output swfr_pkg::out_item_t out_data
);

  localparam int FRAME_BYTES = PAYLOAD_BYTES + 4;
  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CNT_BITS = $clog2(swfr_pkg::QUEUE_DEPTH + 1);

  logic [7:0]          frame_mem [FRAME_BYTES];
  logic [7:0]          rdata_r;
  logic                s1_valid_r;
  logic                s1_rd_r;
  swfr_pkg::out_item_t s1_item_r;
  swfr_pkg::out_item_t res_item;
  logic [CNT_BITS-1:0] oq_count;
  logic                room;
  logic                issue;

  // Issue a result-bearing command only when the output queue has a free slot
  assign room    = ((oq_count + CNT_BITS'(s1_valid_r)) < CNT_BITS'(swfr_pkg::QUEUE_DEPTH));
  assign issue   = !cmd_empty && (!cmd.emit || room);
  assign cmd_pop = issue;

  always_ff @(posedge clk) begin
    if (issue && cmd.wr_en) begin
      frame_mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
    end
    if (issue && cmd.rd_en) begin
      rdata_r <= frame_mem[cmd.rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue && cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r <= cmd.item;
      s1_rd_r   <= cmd.rd_en;
    end
  end

  always_comb begin
    res_item = s1_item_r;
    if (s1_rd_r) begin
      res_item.read_data = rdata_r;
    end
  end

  swfr_queue #(
    .item_t (swfr_pkg::out_item_t),
    .DEPTH  (swfr_pkg::QUEUE_DEPTH)
  ) u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_item (res_item),
    .full      (),
    .pop       (out_pop),
    .pop_item  (out_data),
    .empty     (out_empty),
    .count     (oq_count)
  );

endmodule

FILE: sv/stop_and_wait_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_unit
// Stop-and-wait frame receiver: checks frames, answers ACK/NAK, delivers
// payload and serves payload reads.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_full is low: a frame byte or a payload
// read. The front end keeps the end-around-carry checksum, sequence and
// message length; frame_end on the last byte yields a verdict (oversize
// frames yield none). A result reaches the out_ ports after passing the
// command queue, the frame store read register and the output queue, in
// that order. The frame store is a single memory with one write and one
// read port, so a read sees every frame byte accepted before it. in_full
// rises only when out_pop holds off long enough to fill the four-entry
// command queue. No clearing pass after reset; payload reads before the
// first frame return zero data.
// ----------------------------------------------------------------------------
module stop_and_wait_frame_receiver_unit #(
  parameter int PAYLOAD_BYTES = swfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int LENGTH_BITS   = swfr_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  swfr_pkg::in_item_t  in_data,
  output logic                in_full,
  output logic                out_empty,
  input  logic                out_pop,
  output swfr_pkg::out_item_t out_data
);

  swfr_pkg::cmd_t front_cmd;
  swfr_pkg::cmd_t back_cmd;
  logic           front_push;
  logic           cmd_full;
  logic           cmd_empty;
  logic           back_pop;

  swfr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  swfr_queue #(
    .item_t (swfr_pkg::cmd_t),
    .DEPTH  (swfr_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_item (front_cmd),
    .full      (cmd_full),
    .pop       (back_pop),
    .pop_item  (back_cmd),
    .empty     (cmd_empty),
    .count     ()
  );

  swfr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd       (back_cmd),
    .cmd_pop   (back_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
